/* rtl/core/fw2_pkg.sv */
// Package for the 2D Fenwick range-add / range-sum unit.
// Holds the channel payload types, the tree word and the memory request struct.
// No dependencies.
`default_nettype none

package fw2_pkg;

    // Default grid size
    localparam int unsigned ROWS_DEF = 128;
    localparam int unsigned COLS_DEF = 128;

    // Field widths fixed by the item format
    localparam int unsigned CRD_W = 7;
    localparam int unsigned VAL_W = 64;

    // Widest memory address over the supported grid sizes (4096 x 4096)
    localparam int unsigned MEM_AW_MAX = 24;

    // Operation codes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [CRD_W-1:0]        row_first;
        logic [CRD_W-1:0]        col_first;
        logic [CRD_W-1:0]        row_last;
        logic [CRD_W-1:0]        col_last;
        logic signed [VAL_W-1:0] add_value;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] rect_sum;
    } t_rsp;

    // One entry of the four trees, stored side by side
    typedef struct packed {
        logic [VAL_W-1:0] plain;
        logic [VAL_W-1:0] row_w;
        logic [VAL_W-1:0] col_w;
        logic [VAL_W-1:0] both_w;
    } t_cell;

    // Port access from the sequencer to the tree memory
    typedef struct packed {
        logic                  we;
        logic [MEM_AW_MAX-1:0] waddr;
        t_cell                 wdata;
        logic                  re;
        logic [MEM_AW_MAX-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* rtl/core/fw2_stream_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on fw2_pkg for the payload types.
`default_nettype none

interface fw2_req_if;
    import fw2_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fw2_rsp_if;
    import fw2_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/fenwick_2d_range_add_range_sum_unit.sv */
// 2D Fenwick range-add / range-sum unit. One item at a time; per corner or prefix
// the walk makes one tree read per cycle. A query result enters the output register
// and may wait there while the next item runs. After reset a clearing pass writes
// zero to all ROWS*COLS entries, one per cycle, with the request channel held not ready.
`default_nettype none

module fenwick_2d_range_add_range_sum_unit
    import fw2_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEF,
    parameter int unsigned COLS = COLS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fw2_req_if.sink   i_req,
    fw2_rsp_if.source o_rsp
);

    t_mem_req mem_req;
    t_cell    mem_rdata;

    // Sequencer
    fw2_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    // Tree storage
    fw2_tree_mem #(
        .DEPTH (ROWS * COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* rtl/core/fw2_tree_mem.sv */
// Single-port-write, single-port-read memory holding the four tree words.
// Read data is registered. Depends on fw2_pkg.
`default_nettype none

module fw2_tree_mem
    import fw2_pkg::*;
#(
    parameter int unsigned DEPTH = ROWS_DEF * COLS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_cell         o_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/fw2_ctrl.sv */
// Sequencer for the 2D Fenwick unit: clearing pass, corner walks with
// read-modify-write of the tree memory, prefix walks and weighted combine.
// Depends on fw2_pkg and fw2_stream_if.
`default_nettype none

module fw2_ctrl
    import fw2_pkg::*;
#(
    parameter int unsigned ROWS = ROWS_DEF,
    parameter int unsigned COLS = COLS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fw2_req_if.sink    i_req,
    fw2_rsp_if.source  o_rsp,
    output t_mem_req   o_mem,
    input  wire t_cell i_rdata
);

    localparam int unsigned DEPTH = ROWS * COLS;
    localparam int unsigned AW    = $clog2(DEPTH);
    // Walk coordinates hold corner values up to 128 and x + lowbit(x) < 2*ROWS
    localparam int unsigned XW = ($clog2(ROWS) + 1 > 8) ? $clog2(ROWS) + 1 : 8;
    localparam int unsigned YW = ($clog2(COLS) + 1 > 8) ? $clog2(COLS) + 1 : 8;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CLEAR = 12'b0000_0000_0010,
        ST_SETUP = 12'b0000_0000_0100,
        ST_MUL1  = 12'b0000_0000_1000,
        ST_MUL2  = 12'b0000_0001_0000,
        ST_WALK  = 12'b0000_0010_0000,
        ST_DRAIN = 12'b0000_0100_0000,
        ST_MIX1  = 12'b0000_1000_0000,
        ST_MIX2  = 12'b0001_0000_0000,
        ST_MIX3  = 12'b0010_0000_0000,
        ST_NEXT  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic             r_op;
    logic [CRD_W-1:0] r_r1, r_c1, r_r2, r_c2;
    logic [VAL_W-1:0] r_val;
    logic [1:0]       r_task;
    logic [XW-1:0]    r_row0, r_x;
    logic [YW-1:0]    r_col0, r_y;
    logic             r_neg;
    logic [VAL_W-1:0] r_d0, r_d1, r_d2, r_d3;
    logic             r_p_valid;
    logic [AW-1:0]    r_p_addr;
    logic [VAL_W-1:0] r_s0, r_s1, r_s2, r_s3;
    logic [VAL_W-1:0] r_t0, r_t1, r_t2;
    logic [VAL_W-1:0] r_acc;
    logic [AW-1:0]    r_clr;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_sum;

    // Corner / prefix selection
    logic [7:0]    c_row, c_col;
    logic          c_neg, c_row_neg, c_col_neg;
    logic [XW-1:0] c_x;
    logic [YW-1:0] c_y;
    logic          c_skip;

    always_comb begin
        c_row     = {1'b0, r_r1};
        c_col     = {1'b0, r_c1};
        c_neg     = 1'b0;
        c_row_neg = 1'b0;
        c_col_neg = 1'b0;
        if (r_op == OP_UPDATE) begin
            case (r_task)
                2'd0: begin
                    c_row = {1'b0, r_r1};
                    c_col = {1'b0, r_c1};
                end
                2'd1: begin
                    c_row = {1'b0, r_r1};
                    c_col = {1'b0, r_c2} + 8'd1;
                    c_neg = 1'b1;
                end
                2'd2: begin
                    c_row = {1'b0, r_r2} + 8'd1;
                    c_col = {1'b0, r_c1};
                    c_neg = 1'b1;
                end
                default: begin
                    c_row = {1'b0, r_r2} + 8'd1;
                    c_col = {1'b0, r_c2} + 8'd1;
                end
            endcase
        end else begin
            case (r_task)
                2'd0: begin
                    c_row = {1'b0, r_r2};
                    c_col = {1'b0, r_c2};
                end
                2'd1: begin
                    c_row     = {1'b0, r_r1} - 8'd1;
                    c_col     = {1'b0, r_c2};
                    c_neg     = 1'b1;
                    c_row_neg = (r_r1 == '0);
                end
                2'd2: begin
                    c_row     = {1'b0, r_r2};
                    c_col     = {1'b0, r_c1} - 8'd1;
                    c_neg     = 1'b1;
                    c_col_neg = (r_c1 == '0);
                end
                default: begin
                    c_row     = {1'b0, r_r1} - 8'd1;
                    c_col     = {1'b0, r_c1} - 8'd1;
                    c_row_neg = (r_r1 == '0);
                    c_col_neg = (r_c1 == '0);
                end
            endcase
        end

        c_x = XW'(c_row);
        c_y = YW'(c_col);
        if (r_op == OP_UPDATE) begin
            // Drop corners outside the grid
            c_skip = (c_x == '0) || (c_x >= XW'(ROWS)) || (c_y == '0) || (c_y >= YW'(COLS));
        end else begin
            // Empty prefix counts as zero; clamp to the last row and column
            c_skip = c_row_neg || c_col_neg || (c_x == '0) || (c_y == '0);
            if (c_x > XW'(ROWS - 1)) c_x = XW'(ROWS - 1);
            if (c_y > YW'(COLS - 1)) c_y = YW'(COLS - 1);
        end
    end

    // Walk stepping
    logic [XW-1:0] w_lx, w_x_nx;
    logic [YW-1:0] w_ly, w_y_nx;
    logic          w_x_end, w_y_end;
    logic [AW-1:0] w_addr;

    always_comb begin
        w_lx = r_x & (~r_x + XW'(1));
        w_ly = r_y & (~r_y + YW'(1));
        if (r_op == OP_UPDATE) begin
            w_x_nx  = r_x + w_lx;
            w_y_nx  = r_y + w_ly;
            w_x_end = (w_x_nx >= XW'(ROWS));
            w_y_end = (w_y_nx >= YW'(COLS));
        end else begin
            w_x_nx  = r_x - w_lx;
            w_y_nx  = r_y - w_ly;
            w_x_end = (w_x_nx == '0);
            w_y_end = (w_y_nx == '0);
        end
        w_addr = AW'(r_x) * AW'(COLS) + AW'(r_y);
    end

    logic w_req_fire, w_out_fire, w_fin_load;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_out_fire  = r_out_valid && o_rsp.ready;
    assign w_fin_load  = (r_state == ST_FIN) && (!r_out_valid || o_rsp.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_req_fire) n_state = ST_SETUP;
            ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_SETUP: begin
                if (c_skip)                 n_state = ST_NEXT;
                else if (r_op == OP_UPDATE) n_state = ST_MUL1;
                else                        n_state = ST_WALK;
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_WALK;
            ST_WALK:  if (w_y_end && w_x_end) n_state = ST_DRAIN;
            ST_DRAIN: n_state = (r_op == OP_UPDATE) ? ST_NEXT : ST_MIX1;
            ST_MIX1:  n_state = ST_MIX2;
            ST_MIX2:  n_state = ST_MIX3;
            ST_MIX3:  n_state = ST_NEXT;
            ST_NEXT: begin
                if (r_task != 2'd3)         n_state = ST_SETUP;
                else if (r_op == OP_UPDATE) n_state = ST_IDLE;
                else                        n_state = ST_FIN;
            end
            ST_FIN:   if (w_fin_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == ST_WALK);
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_fin_load)      r_out_valid <= 1'b1;
            else if (w_out_fire) r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    logic [VAL_W-1:0] w_term;
    assign w_term = r_t0 - r_t1 + r_s3;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    r_op   <= i_req.payload.operation;
                    r_r1   <= i_req.payload.row_first;
                    r_c1   <= i_req.payload.col_first;
                    r_r2   <= i_req.payload.row_last;
                    r_c2   <= i_req.payload.col_last;
                    r_val  <= i_req.payload.add_value;
                    r_task <= 2'd0;
                    r_acc  <= '0;
                end
            end
            ST_SETUP: begin
                r_row0 <= c_x;
                r_col0 <= c_y;
                r_x    <= c_x;
                r_y    <= c_y;
                r_neg  <= c_neg;
                r_d0   <= c_neg ? (VAL_W'(0) - r_val) : r_val;
            end
            ST_MUL1: begin
                r_d1 <= r_d0 * VAL_W'(r_row0);
                r_d2 <= r_d0 * VAL_W'(r_col0);
            end
            ST_MUL2: begin
                r_d3 <= r_d1 * VAL_W'(r_col0);
            end
            ST_WALK: begin
                r_p_addr <= w_addr;
                if (w_y_end) begin
                    r_x <= w_x_nx;
                    r_y <= r_col0;
                end else begin
                    r_y <= w_y_nx;
                end
            end
            ST_MIX1: begin
                r_t0 <= r_s0 * (VAL_W'(r_row0) + VAL_W'(1));
                r_t1 <= r_s1 * (VAL_W'(r_col0) + VAL_W'(1));
                r_t2 <= r_s2 * (VAL_W'(r_row0) + VAL_W'(1));
            end
            ST_MIX2: begin
                r_t0 <= r_t0 * (VAL_W'(r_col0) + VAL_W'(1));
                r_t1 <= r_t1 + r_t2;
            end
            ST_MIX3: begin
                r_acc <= r_neg ? (r_acc - w_term) : (r_acc + w_term);
            end
            ST_NEXT: begin
                r_task <= r_task + 2'd1;
            end
            default: begin
            end
        endcase

        // Prefix accumulators: clear per prefix, add each returned entry
        if (r_state == ST_SETUP) begin
            r_s0 <= '0;
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (r_p_valid && (r_op == OP_QUERY)) begin
            r_s0 <= r_s0 + i_rdata.plain;
            r_s1 <= r_s1 + i_rdata.row_w;
            r_s2 <= r_s2 + i_rdata.col_w;
            r_s3 <= r_s3 + i_rdata.both_w;
        end

        if (w_fin_load) r_out_sum <= r_acc;
    end

    // Memory port: clearing pass, walk reads, write-back in the cycle after each read.
    // Cells of one walk are distinct and the drain cycle finishes the last
    // write before the next walk starts, so no read sees a pending write.
    always_comb begin
        o_mem       = '0;
        o_mem.re    = (r_state == ST_WALK);
        o_mem.raddr = MEM_AW_MAX'(w_addr);
        if (r_state == ST_CLEAR) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = MEM_AW_MAX'(r_clr);
        end else begin
            o_mem.we           = r_p_valid && (r_op == OP_UPDATE);
            o_mem.waddr        = MEM_AW_MAX'(r_p_addr);
            o_mem.wdata.plain  = i_rdata.plain  + r_d0;
            o_mem.wdata.row_w  = i_rdata.row_w  + r_d1;
            o_mem.wdata.col_w  = i_rdata.col_w  + r_d2;
            o_mem.wdata.both_w = i_rdata.both_w + r_d3;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.payload.rect_sum = r_out_sum;

endmodule

`default_nettype wire

/* rtl/core/fw2_chk.sv */
// Port-level checker for the 2D Fenwick unit, bound to the top level.
// Depends on fw2_pkg for field widths.
`default_nettype none

module fw2_chk
    import fw2_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire logic [VAL_W-1:0] i_rsp_sum
);

    // Reset starts the clearing pass: no request is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready right after reset");

    // One item at a time: a transfer in is followed by a busy cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request ready in the cycle after a transfer");

    // A result does not rise straight after the request transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !$rose(i_rsp_valid))
        else $error("result appeared one cycle after a request transfer");

    // A stalled result holds its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_sum)))
        else $error("stalled result dropped or changed");

endmodule

bind fenwick_2d_range_add_range_sum_unit fw2_chk u_fw2_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_sum   (o_rsp.payload.rect_sum)
);

`default_nettype wire

/* tb/fw2_tb_pkg.sv */
// Testbench helpers for the 2D Fenwick range-add / range-sum unit.
// Holds the grid size used by the bench. Depends on fw2_pkg.
`timescale 1ns / 1ps

package fw2_tb_pkg;
    import fw2_pkg::*;
    localparam int GRID_ROWS = ROWS_DEF;
    localparam int GRID_COLS = COLS_DEF;
endpackage

/* tb/fenwick_2d_range_add_range_sum_unit_tb.sv */
// Self-checking bench for the 2D Fenwick range-add / range-sum unit.
// Predicts rectangle sums with a shadow set of four trees and checks each transfer.
// Depends on fw2_pkg, fw2_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module fenwick_2d_range_add_range_sum_unit_tb;
    import fw2_pkg::*;
    import fw2_tb_pkg::*;

    localparam int NUM_RANDOM = 1330;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fw2_req_if req_ch ();
    fw2_rsp_if rsp_ch ();

    fenwick_2d_range_add_range_sum_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Shadow trees, one word each for D, D*row, D*col, D*row*col
    logic [63:0] sh_plain [GRID_ROWS*GRID_COLS];
    logic [63:0] sh_row   [GRID_ROWS*GRID_COLS];
    logic [63:0] sh_col   [GRID_ROWS*GRID_COLS];
    logic [63:0] sh_both  [GRID_ROWS*GRID_COLS];

    t_req        pending_reqs [$];
    logic [63:0] expected_sums [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          stim_done = 0;
    bit          sink_hold = 0;

    function automatic void add_corner(int r, int c, logic [63:0] v);
        logic [63:0] vr, vc, vrc;
        int x, y, k;
        if (r <= 0 || r >= GRID_ROWS || c <= 0 || c >= GRID_COLS) return;
        vr = v * 64'(r);
        vc = v * 64'(c);
        vrc = vr * 64'(c);
        for (x = r; x < GRID_ROWS; x += x & (-x))
            for (y = c; y < GRID_COLS; y += y & (-y)) begin
                k = x * GRID_COLS + y;
                sh_plain[k] += v;
                sh_row[k] += vr;
                sh_col[k] += vc;
                sh_both[k] += vrc;
            end
    endfunction

    function automatic logic [63:0] prefix_total(int r, int c);
        logic [63:0] s0, s1, s2, s3, wr, wc;
        int x, y, k;
        s0 = 0; s1 = 0; s2 = 0; s3 = 0;
        if (r <= 0 || c <= 0) return 64'd0;
        if (r > GRID_ROWS - 1) r = GRID_ROWS - 1;
        if (c > GRID_COLS - 1) c = GRID_COLS - 1;
        for (x = r; x > 0; x -= x & (-x))
            for (y = c; y > 0; y -= y & (-y)) begin
                k = x * GRID_COLS + y;
                s0 += sh_plain[k];
                s1 += sh_row[k];
                s2 += sh_col[k];
                s3 += sh_both[k];
            end
        wr = 64'(r + 1);
        wc = 64'(c + 1);
        return s0 * wr * wc - s1 * wc - s2 * wr + s3;
    endfunction

    // Apply one accepted item to the shadow trees, queue the sum for queries
    function automatic void predict_item(t_req it);
        int r1, c1, r2, c2;
        logic [63:0] v;
        r1 = it.row_first; c1 = it.col_first; r2 = it.row_last; c2 = it.col_last;
        v = it.add_value;
        if (it.operation == OP_UPDATE) begin
            add_corner(r1, c1, v);
            add_corner(r1, c2 + 1, -v);
            add_corner(r2 + 1, c1, -v);
            add_corner(r2 + 1, c2 + 1, v);
        end else begin
            expected_sums.push_back(prefix_total(r2, c2) - prefix_total(r1 - 1, c2)
                - prefix_total(r2, c1 - 1) + prefix_total(r1 - 1, c1 - 1));
        end
    endfunction

    function automatic t_req make_item(logic op, int r1, int c1, int r2, int c2,
                                       logic [63:0] v);
        t_req it;
        it.operation = op;
        it.row_first = r1[6:0];
        it.col_first = c1[6:0];
        it.row_last  = r2[6:0];
        it.col_last  = c2[6:0];
        it.add_value = v;
        return it;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(0, 200)) - 100);
            2: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            3: return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    // Mostly well-formed rectangles, small ones often; some inverted
    function automatic t_req rand_item();
        int r1, c1, r2, c2, t;
        logic op;
        op = 1'($urandom_range(0, 1));
        r1 = $urandom_range(1, 127);
        c1 = $urandom_range(1, 127);
        if ($urandom_range(0, 3) == 0) begin
            r2 = $urandom_range(1, 127);
            c2 = $urandom_range(1, 127);
        end else begin
            r2 = r1 + $urandom_range(0, 20);
            c2 = c1 + $urandom_range(0, 20);
            if (r2 > 127) r2 = 127;
            if (c2 > 127) c2 = 127;
        end
        if ($urandom_range(0, 9) != 0) begin
            if (r1 > r2) begin t = r1; r1 = r2; r2 = t; end
            if (c1 > c2) begin t = c1; c1 = c2; c2 = t; end
        end
        return make_item(op, r1, c1, r2, c2, rand_value());
    endfunction

    // Driver: offer queued items with random gaps
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.payload <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) predict_item(req_ch.payload);
            if (!req_ch.valid || req_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_ch.payload <= pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    src_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                             : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random ready, compare each transfer with the oldest expected sum
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected result %0d", $time, rsp_ch.payload.rect_sum);
                    error_count++;
                end else if (rsp_ch.payload.rect_sum !== $signed(expected_sums[0])) begin
                    $display("%0t: rect_sum mismatch expected %0d actual %0d", $time,
                             $signed(expected_sums[0]), rsp_ch.payload.rect_sum);
                    error_count++;
                    void'(expected_sums.pop_front());
                end else begin
                    void'(expected_sums.pop_front());
                end
            end
            rsp_ch.ready <= !sink_hold && ($urandom_range(0, 9) < 7);
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, full grid, single cells, inverted and edge rectangles
        pending_reqs.push_back(make_item(OP_QUERY, 1, 1, 127, 127, 64'd5));
        pending_reqs.push_back(make_item(OP_UPDATE, 1, 1, 127, 127, 64'd1));
        pending_reqs.push_back(make_item(OP_QUERY, 1, 1, 127, 127, 0));
        pending_reqs.push_back(make_item(OP_UPDATE, 127, 127, 127, 127,
                                         64'h7FFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(make_item(OP_UPDATE, 1, 1, 1, 1, 64'h8000_0000_0000_0000));
        pending_reqs.push_back(make_item(OP_QUERY, 127, 127, 127, 127, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_reqs.push_back(make_item(OP_QUERY, 1, 1, 1, 1, 0));
        pending_reqs.push_back(make_item(OP_UPDATE, 0, 0, 0, 0, 64'd9));
        pending_reqs.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_item(OP_UPDATE, 50, 60, 20, 10, -64'sd7));
        pending_reqs.push_back(make_item(OP_QUERY, 90, 100, 5, 3, 0));
        pending_reqs.push_back(make_item(OP_UPDATE, 42, 85, 42, 85, 64'hAAAA_5555_AAAA_5555));
        pending_reqs.push_back(make_item(OP_QUERY, 1, 64, 127, 64, 0));
        pending_reqs.push_back(make_item(OP_QUERY, 0, 1, 127, 0, 0));
        pending_reqs.push_back(make_item(OP_QUERY, 1, 1, 127, 127, 0));
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        // Sender pause until every result is back
        wait (expected_sums.size() == 0);

        // Receiver holds off while items keep coming
        fork
            begin
                sink_hold = 1;
                repeat (3000) @(posedge i_clk);
                sink_hold = 0;
            end
        join_none
        for (i = 0; i < 20; i++)
            pending_reqs.push_back(make_item(OP_QUERY, $urandom_range(1, 127),
                $urandom_range(1, 127), 127, 127, 0));

        for (i = 0; i < NUM_RANDOM; i++) pending_reqs.push_back(rand_item());
        wait (pending_reqs.size() == 0 && !req_ch.valid);
        wait (expected_sums.size() == 0);
        repeat (500) @(posedge i_clk);
        if (error_count == 0 && expected_sums.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        for (int k = 0; k < GRID_ROWS * GRID_COLS; k++) begin
            sh_plain[k] = 0; sh_row[k] = 0; sh_col[k] = 0; sh_both[k] = 0;
        end
    end
endmodule
